// ----- src/imm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imm_pkg
// Shared widths, register codes and controller/datapath bundles for the
// integer matrix multiply core.
// ----------------------------------------------------------------------------
package imm_pkg;

    // Matrix geometry
    localparam int MAX_DIM   = 8;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int DATA_W    = 32;
    localparam int DIM_W     = 4;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SIZE_W    = ADDR_W + 1;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [DIM_W-1:0]  dim_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  load_en;   // write the accepted element
        logic  load_b;    // 0: matrix A store, 1: matrix B store
        addr_t load_addr;
        logic  rd_en;     // issue one multiply-accumulate term
        addr_t a_addr;
        addr_t b_addr;
        logic  k_first;   // first term of a product element
        logic  k_last;    // last term of a product element
        idx_t  row;
        idx_t  col;
        logic  last;      // final element of the product matrix
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic idle;       // pipeline empty and no result waiting in accumulator
    } sts_t;

    // Out-of-range dimensions clamp to 1..MAX_DIM
    function automatic dim_t eff_dim(input dim_t v);
        dim_t r;
        if (v == '0)
            r = dim_t'(1);
        else if (v > dim_t'(MAX_DIM))
            r = dim_t'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/imm_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imm_if
// Valid/ready channel interfaces: element input, product output and
// configuration write.
// ----------------------------------------------------------------------------
interface imm_elem_if
    import imm_pkg::*;
;
    logic  valid;
    logic  ready;
    data_t element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface imm_prod_if
    import imm_pkg::*;
;
    logic  valid;
    logic  ready;
    data_t product_value;
    idx_t  row_index;
    idx_t  col_index;
    logic  last_flag;

    modport source (output valid, output product_value, output row_index,
                    output col_index, output last_flag, input ready);
    modport sink   (input valid, input product_value, input row_index,
                    input col_index, input last_flag, output ready);
endinterface

interface imm_cfg_if
    import imm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    dim_t                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/imm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imm_ctrl
// Controller: holds the dimension registers, sequences the load of A and B,
// then walks row, column and inner index to issue multiply-accumulate terms.
// ----------------------------------------------------------------------------
module imm_ctrl
    import imm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire dim_t                 cfg_data,
    input  wire sts_t                 sts,
    output cmd_t                      cmd
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    dim_t        rows_reg, inner_reg, cols_reg;
    addr_t       cnt_reg;
    logic        phase_b_reg;
    idx_t        r_reg, c_reg, k_reg;
    logic        done_reg;

    dim_t        m_eff, n_eff, p_eff;
    logic [SIZE_W-1:0] size_a, size_b, cnt_plus;
    logic        accept, cfg_wr, load_last, k_end, r_end, c_end;

    assign m_eff  = eff_dim(rows_reg);
    assign n_eff  = eff_dim(inner_reg);
    assign p_eff  = eff_dim(cols_reg);
    assign size_a = SIZE_W'(m_eff) * SIZE_W'(n_eff);
    assign size_b = SIZE_W'(n_eff) * SIZE_W'(p_eff);

    assign in_ready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign cfg_wr    = cfg_valid && (cfg_index == REG_ROWS_A || cfg_index == REG_INNER_SIZE
                                     || cfg_index == REG_COLS_B);

    assign cnt_plus  = SIZE_W'(cnt_reg) + SIZE_W'(1);
    assign load_last = phase_b_reg && (cnt_plus == size_b);

    assign k_end = ({1'b0, k_reg} == n_eff - dim_t'(1));
    assign r_end = ({1'b0, r_reg} == m_eff - dim_t'(1));
    assign c_end = ({1'b0, c_reg} == p_eff - dim_t'(1));

    // Command bundle
    always_comb
    begin
        cmd.load_en   = accept;
        cmd.load_b    = phase_b_reg;
        cmd.load_addr = cnt_reg;
        cmd.rd_en     = (state_reg == ST_ISSUE);
        cmd.a_addr    = addr_t'(ADDR_W'(r_reg) * ADDR_W'(n_eff) + ADDR_W'(k_reg));
        cmd.b_addr    = addr_t'(ADDR_W'(k_reg) * ADDR_W'(p_eff) + ADDR_W'(c_reg));
        cmd.k_first   = (k_reg == '0);
        cmd.k_last    = k_end;
        cmd.row       = r_reg;
        cmd.col       = c_reg;
        cmd.last      = r_end && c_end;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && load_last)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (k_end)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.idle)
                    state_next = done_reg ? ST_LOAD : ST_ISSUE;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            rows_reg    <= dim_t'(MAX_DIM);
            inner_reg   <= dim_t'(MAX_DIM);
            cols_reg    <= dim_t'(MAX_DIM);
            cnt_reg     <= '0;
            phase_b_reg <= 1'b0;
            r_reg       <= '0;
            c_reg       <= '0;
            k_reg       <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes restart the load
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_ROWS_A:     rows_reg  <= cfg_data;
                    REG_INNER_SIZE: inner_reg <= cfg_data;
                    REG_COLS_B:     cols_reg  <= cfg_data;
                    default:        ;
                endcase
                cnt_reg     <= '0;
                phase_b_reg <= 1'b0;
            end
            else if (accept)
            begin
                if (!phase_b_reg && cnt_plus == size_a)
                begin
                    cnt_reg     <= '0;
                    phase_b_reg <= 1'b1;
                end
                else if (load_last)
                begin
                    cnt_reg     <= '0;
                    phase_b_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= addr_t'(cnt_plus);
                end
            end

            // inner index, then column, then row
            if (state_reg == ST_ISSUE)
            begin
                if (k_end)
                begin
                    k_reg    <= '0;
                    done_reg <= r_end && c_end;
                    if (c_end)
                    begin
                        c_reg <= '0;
                        r_reg <= r_end ? '0 : r_reg + idx_t'(1);
                    end
                    else
                    begin
                        c_reg <= c_reg + idx_t'(1);
                    end
                end
                else
                begin
                    k_reg <= k_reg + idx_t'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/imm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imm_datapath
// Matrix stores, read / multiply / accumulate pipeline and the output
// register that holds a product element until the sink takes it.
// ----------------------------------------------------------------------------
module imm_datapath
    import imm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cmd_t  cmd,
    input  wire data_t element_value,
    output sts_t       sts,
    output logic       out_valid,
    input  wire logic  out_ready,
    output data_t      product_value,
    output idx_t       row_index,
    output idx_t       col_index,
    output logic       last_flag
);

    data_t mem_a [DEPTH];
    data_t mem_b [DEPTH];

    // stage 1: read data
    logic  s1_v_reg;
    data_t a_rd_reg, b_rd_reg;
    logic  s1_first_reg, s1_klast_reg, s1_end_reg;
    idx_t  s1_row_reg, s1_col_reg;

    // stage 2: product
    logic  s2_v_reg;
    data_t prod_reg;
    logic  s2_first_reg, s2_klast_reg, s2_end_reg;
    idx_t  s2_row_reg, s2_col_reg;

    // stage 3: accumulator
    logic  acc_full_reg;
    data_t acc_reg;
    logic  acc_end_reg;
    idx_t  acc_row_reg, acc_col_reg;

    // output register
    logic  out_v_reg;
    data_t out_val_reg;
    logic  out_end_reg;
    idx_t  out_row_reg, out_col_reg;

    data_t mul_full;
    logic  out_free, move_out;

    // low word of the product; the sum wraps at 32 bits anyway
    assign mul_full = a_rd_reg * b_rd_reg;
    assign out_free = !out_v_reg || out_ready;
    assign move_out = acc_full_reg && out_free;

    assign sts.idle = !s1_v_reg && !s2_v_reg && !acc_full_reg;

    assign out_valid     = out_v_reg;
    assign product_value = out_val_reg;
    assign row_index     = out_row_reg;
    assign col_index     = out_col_reg;
    assign last_flag     = out_end_reg;

    // Matrix stores
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && !cmd.load_b)
            mem_a[cmd.load_addr] <= element_value;
        if (cmd.rd_en)
            a_rd_reg <= mem_a[cmd.a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && cmd.load_b)
            mem_b[cmd.load_addr] <= element_value;
        if (cmd.rd_en)
            b_rd_reg <= mem_b[cmd.b_addr];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            acc_full_reg <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.rd_en;
            s2_v_reg <= s1_v_reg;
            if (s2_v_reg && s2_klast_reg)
                acc_full_reg <= 1'b1;
            else if (move_out)
                acc_full_reg <= 1'b0;
            if (move_out)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.k_first;
        s1_klast_reg <= cmd.k_last;
        s1_end_reg   <= cmd.last;
        s1_row_reg   <= cmd.row;
        s1_col_reg   <= cmd.col;

        prod_reg     <= mul_full;
        s2_first_reg <= s1_first_reg;
        s2_klast_reg <= s1_klast_reg;
        s2_end_reg   <= s1_end_reg;
        s2_row_reg   <= s1_row_reg;
        s2_col_reg   <= s1_col_reg;

        // wrapping multiply-accumulate
        if (s2_v_reg)
        begin
            acc_reg <= s2_first_reg ? prod_reg : acc_reg + prod_reg;
            if (s2_klast_reg)
            begin
                acc_end_reg <= s2_end_reg;
                acc_row_reg <= s2_row_reg;
                acc_col_reg <= s2_col_reg;
            end
        end

        if (move_out)
        begin
            out_val_reg <= acc_reg;
            out_end_reg <= acc_end_reg;
            out_row_reg <= acc_row_reg;
            out_col_reg <= acc_col_reg;
        end
    end

endmodule
`default_nettype wire

// ----- src/integer_matrix_multiply_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core
// Signed 32-bit matrix product C = A * B with wrapping accumulation.
// ----------------------------------------------------------------------------
// Elements enter one per cycle while the input is open: A (rows_a x
// inner_size) row-major, then B (inner_size x cols_b) row-major. After the
// last element of B the input stalls while C is produced row-major; each
// product element issues one term per cycle through the read / multiply /
// accumulate pipeline, then the pipeline drains before the next element
// starts. A finished element waits in an output register, so the next one
// is computed while the sink holds off; the input opens again once the last
// element has left the accumulator. Dimension values of 0 act as 1 and values
// above 8 act as 8. Writing a dimension register restarts the load. Product
// transactions carry row, column and a flag on the final one.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_core
    import imm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    imm_elem_if.sink  element,
    imm_prod_if.source product,
    imm_cfg_if.sink   cfg
);

    cmd_t cmd;
    sts_t sts;

    // Sequencing and configuration
    imm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (element.valid),
        .in_ready  (element.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Stores and arithmetic
    imm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .element_value (element.element_value),
        .sts           (sts),
        .out_valid     (product.valid),
        .out_ready     (product.ready),
        .product_value (product.product_value),
        .row_index     (product.row_index),
        .col_index     (product.col_index),
        .last_flag     (product.last_flag)
    );

    // Loading only happens with an empty arithmetic pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (element.valid && element.ready) |-> sts.idle)
        else $error("element accepted while pipeline busy");

    // Term issue and loading never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !element.ready)
        else $error("input open during compute");

    // A finished accumulation never arrives while the previous one still waits
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !$past(sts.idle) || sts.idle || cmd.k_first || $past(cmd.rd_en))
        else $error("term issued into a busy accumulator");

endmodule
`default_nettype wire

// ----- tb/imm_product_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_product_checker
// Watches the element, product and configuration channels of the matrix
// multiply core. It keeps its own copy of both matrix stores, the fill
// position and the dimensions, and works out the product transactions that
// each completed load must yield. Every product transaction is compared
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module imm_product_checker
    import imm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    imm_elem_if       elem,
    imm_prod_if       prod,
    imm_cfg_if        cfg,
    output int        fail_count,
    output int        pending,
    output int        load_size,
    output int        elements_seen,
    output int        products_seen,
    output int        loads_done,
    output int        reg_writes
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        data_t value;
        idx_t  row;
        idx_t  col;
        logic  last;
    } product_t;

    product_t    expected_products[$];
    data_t       a_store [DEPTH];
    data_t       b_store [DEPTH];
    int unsigned fill_count;
    dim_t        rows_cfg;
    dim_t        inner_cfg;
    dim_t        cols_cfg;

    // Register value as the block uses it: zero acts as one, large values as 8
    function automatic int unsigned usable_dim(input dim_t v);
        int unsigned d;
        d = int'(v);
        if (d == 0)
            d = 1;
        else if (d > MAX_DIM)
            d = MAX_DIM;
        return d;
    endfunction

    // Row-major product of the stored matrices, sums wrap at 32 bits
    function automatic void form_products(input int unsigned m, input int unsigned n,
                                          input int unsigned p);
        data_t    acc;
        product_t item;
        for (int unsigned r = 0; r < m; r++) begin
            for (int unsigned c = 0; c < p; c++) begin
                acc = '0;
                for (int unsigned k = 0; k < n; k++)
                    acc = acc + a_store[(r * n + k) % DEPTH] * b_store[(k * p + c) % DEPTH];
                item.value = acc;
                item.row   = idx_t'(r);
                item.col   = idx_t'(c);
                item.last  = (r == m - 1) && (c == p - 1);
                expected_products.push_back(item);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        product_t    got;
        product_t    want;
        int unsigned m;
        int unsigned n;
        int unsigned p;
        if (!rst_n) begin
            expected_products.delete();
            fill_count    = 0;
            rows_cfg      = dim_t'(MAX_DIM);
            inner_cfg     = dim_t'(MAX_DIM);
            cols_cfg      = dim_t'(MAX_DIM);
            fail_count    = 0;
            elements_seen = 0;
            products_seen = 0;
            loads_done    = 0;
            reg_writes    = 0;
        end else begin
            // Product side: compare against the oldest expectation
            if (prod.valid && prod.ready) begin
                products_seen++;
                got.value = prod.product_value;
                got.row   = prod.row_index;
                got.col   = prod.col_index;
                got.last  = prod.last_flag;
                if (expected_products.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected product: value=%h row=%0d col=%0d last=%0b",
                                 $realtime, got.value, got.row, got.col, got.last);
                end else begin
                    want = expected_products.pop_front();
                    if (got.value !== want.value || got.row !== want.row ||
                        got.col !== want.col || got.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"[%0t] product mismatch: expected value=%h row=%0d ",
                                      "col=%0d last=%0b, got value=%h row=%0d col=%0d ",
                                      "last=%0b"},
                                     $realtime, want.value, want.row, want.col, want.last,
                                     got.value, got.row, got.col, got.last);
                    end
                end
            end

            // Register writes restart the load; the spare index does nothing
            if (cfg.valid && cfg.ready) begin
                reg_writes++;
                case (cfg.index)
                    REG_ROWS_A:
                    begin
                        rows_cfg   = cfg.data;
                        fill_count = 0;
                    end
                    REG_INNER_SIZE:
                    begin
                        inner_cfg  = cfg.data;
                        fill_count = 0;
                    end
                    REG_COLS_B:
                    begin
                        cols_cfg   = cfg.data;
                        fill_count = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Element side: A first, then B; the last element of B fires the product
            if (elem.valid && elem.ready) begin
                elements_seen++;
                m = usable_dim(rows_cfg);
                n = usable_dim(inner_cfg);
                p = usable_dim(cols_cfg);
                if (fill_count < m * n)
                    a_store[fill_count % DEPTH] = elem.element_value;
                else
                    b_store[(fill_count - m * n) % DEPTH] = elem.element_value;
                fill_count++;
                if (fill_count >= m * n + n * p) begin
                    fill_count = 0;
                    loads_done++;
                    form_products(m, n, p);
                end
            end
        end
        pending   <= expected_products.size();
        load_size <= usable_dim(rows_cfg) * usable_dim(inner_cfg)
                     + usable_dim(inner_cfg) * usable_dim(cols_cfg);
    end

endmodule

// ----- tb/tb_integer_matrix_multiply_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_matrix_multiply_core
// Stimulus and verdict for the integer matrix multiply core. A short directed
// section hits wrapping products, clamped dimensions, an aborted load and the
// unused register index; then random dimensions and element values drive
// complete loads, with a few aborted ones, one full 8x8x8 load and random
// gaps and stalls on both channels. A checker beside the core predicts and
// compares every product transaction.
// ----------------------------------------------------------------------------
module tb_integer_matrix_multiply_core;
    import imm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int WATCHDOG_NS   = 1_000_000;
    localparam int TARGET_ITEMS  = 330;
    localparam int CALM_AFTER    = 280;
    localparam int SETTLE_CYCLES = 2 * MAX_DIM + 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int          items_sent = 0;

    int fail_count;
    int pending;
    int load_size;
    int elements_seen;
    int products_seen;
    int loads_done;
    int reg_writes;

    imm_elem_if elem_ch ();
    imm_prod_if prod_ch ();
    imm_cfg_if  cfg_ch ();

    integer_matrix_multiply_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .element (elem_ch),
        .product (prod_ch),
        .cfg     (cfg_ch)
    );

    imm_product_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .elem          (elem_ch),
        .prod          (prod_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .load_size     (load_size),
        .elements_seen (elements_seen),
        .products_seen (products_seen),
        .loads_done    (loads_done),
        .reg_writes    (reg_writes)
    );

    always #CLK_HALF clk = ~clk;

    // Product sink: random stall bursts while idling is on
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            prod_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left    <= $urandom_range(0, 3);
            prod_ch.ready <= 1'b0;
        end else
            prod_ch.ready <= 1'b1;
    end

    // Mostly extremes and small values, the rest fully random
    function automatic data_t pick_element();
        data_t v;
        case ($urandom_range(0, 7))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'hffff_ffff;
            3: v = '0;
            4: v = data_t'(int'($urandom_range(0, 30)) - 15);
            default: v = data_t'($urandom);
        endcase
        return v;
    endfunction

    // Mostly small sizes, sometimes zero, eight or out of range
    function automatic dim_t pick_dim();
        dim_t d;
        case ($urandom_range(0, 9))
            0: d = dim_t'(0);
            1: d = dim_t'($urandom_range(9, 15));
            2: d = dim_t'(MAX_DIM);
            3: d = dim_t'($urandom_range(4, 7));
            default: d = dim_t'($urandom_range(1, 3));
        endcase
        return d;
    endfunction

    // One element transaction, with an optional gap in front
    task automatic send_element(input data_t v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            elem_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        elem_ch.valid         <= 1'b1;
        elem_ch.element_value <= v;
        do
            @(posedge clk);
        while (!elem_ch.ready);
        items_sent++;
    endtask

    task automatic feed_random(input int count);
        for (int i = 0; i < count; i++)
            send_element(pick_element());
    endtask

    // One register write transaction, then a quiet gap with valid low
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input dim_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending, wait for every expected product, then let the core settle
    task automatic drain();
        elem_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        int   phase;
        int   total;
        dim_t dr;
        dim_t dn;
        dim_t dp;

        elem_ch.valid         = 1'b0;
        elem_ch.element_value = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_ROWS_A;
        cfg_ch.data           = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1x1x1 with rows written as zero: wrapping extreme products
        write_reg(REG_ROWS_A, dim_t'(0));
        write_reg(REG_INNER_SIZE, dim_t'(1));
        write_reg(REG_COLS_B, dim_t'(1));
        send_element(32'h8000_0000);
        send_element(32'h8000_0000);
        send_element(32'h7fff_ffff);
        send_element(32'h7fff_ffff);
        send_element(32'hffff_ffff);
        send_element(32'h8000_0000);
        drain();

        // 2x2 by 2x1: sums of extremes wrap
        write_reg(REG_ROWS_A, dim_t'(2));
        write_reg(REG_INNER_SIZE, dim_t'(2));
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        send_element(32'h0000_0001);
        send_element(32'hffff_ffff);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        drain();

        // Partial load dropped by a register write; spare index is a no-op
        send_element(32'h1234_5678);
        send_element(32'hdead_beef);
        send_element(32'h0000_0003);
        drain();
        write_reg(REG_COLS_B, dim_t'(2));
        write_reg(REG_SPARE, dim_t'(15));
        feed_random(8);
        drain();

        // Random phases: complete loads, a few aborted ones, one largest load
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            idle_on <= (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            if (phase == 2) begin
                dr = dim_t'(MAX_DIM);
                dn = dim_t'(15);
                dp = dim_t'(MAX_DIM);
            end else begin
                dr = pick_dim();
                dn = pick_dim();
                dp = pick_dim();
            end
            write_reg(REG_ROWS_A, dr);
            write_reg(REG_INNER_SIZE, dn);
            write_reg(REG_COLS_B, dp);
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_SPARE, dim_t'($urandom));
            total = load_size;
            if (phase != 2 && items_sent < CALM_AFTER && $urandom_range(0, 7) == 0)
                feed_random($urandom_range(1, total - 1));
            else
                feed_random(total);
            drain();
            phase++;
        end

        $display("run covered %0d elements in %0d complete loads with %0d register writes",
                 elements_seen, loads_done, reg_writes);
        $display("%0d product transactions checked, %0d failures",
                 products_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("watchdog expired with %0d products outstanding", pending);
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
src/imm_pkg.sv
src/imm_if.sv
src/imm_ctrl.sv
src/imm_datapath.sv
src/integer_matrix_multiply_core.sv
tb/imm_product_checker.sv
tb/tb_integer_matrix_multiply_core.sv
